[rtl/pidl_pkg.sv]
// shared types and constants of the positional insert/delete list
package pidl_pkg;

   localparam int DEPTH   = 32;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = 6;
   localparam int VALUE_W = 32;
   localparam int TDATA_W = 40;

   typedef enum logic [1:0] {
      ACT_APPEND = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_READ   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_EMPTY = 2'd2,
      STS_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      logic capture;
      logic commit_ins;
      logic commit_del;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      action_type action;
      status_type code;
   } dp_status_type;

endpackage

[rtl/pidl_ctrl.sv]
// controller state machine of the positional insert/delete list
module pidl_ctrl
   import pidl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type dp_status,
   output cmd_type       cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      is_write;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign is_write   = (dp_status.action == ACT_APPEND) || (dp_status.action == ACT_INSERT);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.capture    = accept;
      cmd.load_rsp   = (state_ff == ST_EXEC);
      cmd.commit_ins = (state_ff == ST_EXEC) && (dp_status.code == STS_OK) && is_write;
      cmd.commit_del = (state_ff == ST_EXEC) && (dp_status.code == STS_OK)
                       && (dp_status.action == ACT_DELETE);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == ST_EXEC) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_accept_to_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_EXEC)
      else $error("accepted item did not enter execute");
   a_exec_slot_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |-> !rsp_valid_ff)
      else $error("execute while result slot occupied");
   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EXEC |=> rsp_valid_ff && state_ff == ST_IDLE)
      else $error("execute did not present a result");
`endif

endmodule

[rtl/pidl_datapath.sv]
// list storage, shift cells and result register of the positional insert/delete list
module pidl_datapath
   import pidl_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic [TDATA_W-1:0]          req_tdata,
   input  cmd_type                     cmd,
   output dp_status_type               dp_status,
   output logic [TDATA_W-1:0]          rsp_tdata
);

   action_type                 action_ff;
   logic [CNT_W-1:0]           position_ff;
   logic signed [VALUE_W-1:0]  value_ff;
   logic signed [VALUE_W-1:0]  entries_ff [DEPTH];
   logic signed [VALUE_W-1:0]  entries_in [DEPTH];
   logic signed [VALUE_W-1:0]  shift_up   [DEPTH];
   logic signed [VALUE_W-1:0]  shift_dn   [DEPTH];
   logic [CNT_W-1:0]           count_ff, count_in;
   status_type                 code;
   logic [CNT_W-1:0]           ins_pos;
   status_type                 rsp_status_ff;
   logic [CNT_W-1:0]           rsp_count_ff;
   logic signed [VALUE_W-1:0]  rsp_read_ff;
   logic                       is_full, is_empty;

   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign ins_pos  = (action_ff == ACT_APPEND) ? count_ff : position_ff;

   always_comb begin
      unique case (action_ff)
         ACT_APPEND: begin
            code = is_full ? STS_FULL : STS_OK;
         end
         ACT_INSERT: begin
            if (is_full) begin
               code = STS_FULL;
            end else if (position_ff > count_ff) begin
               code = STS_RANGE;
            end else begin
               code = STS_OK;
            end
         end
         default: begin
            if (is_empty) begin
               code = STS_EMPTY;
            end else if (position_ff >= count_ff) begin
               code = STS_RANGE;
            end else begin
               code = STS_OK;
            end
         end
      endcase
   end

   assign dp_status.action = action_ff;
   assign dp_status.code   = code;

   // neighbor taps for the parallel shift
   always_comb begin
      shift_up[0]       = entries_ff[0];
      shift_dn[DEPTH-1] = entries_ff[DEPTH-1];
      for (int k = 1; k < DEPTH; k++) begin
         shift_up[k]   = entries_ff[k-1];
         shift_dn[k-1] = entries_ff[k];
      end
   end

   // each cell compares its index with the position
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         entries_in[k] = entries_ff[k];
         if (cmd.commit_ins) begin
            if (CNT_W'(k) == ins_pos) begin
               entries_in[k] = value_ff;
            end else if (CNT_W'(k) > ins_pos) begin
               entries_in[k] = shift_up[k];
            end
         end else if (cmd.commit_del) begin
            if (CNT_W'(k) >= position_ff) begin
               entries_in[k] = shift_dn[k];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.commit_ins) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.commit_del) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff   <= action_type'(req_tdata[1:0]);
         position_ff <= req_tdata[7:2];
         value_ff    <= $signed(req_tdata[39:8]);
      end
      if (cmd.commit_ins || cmd.commit_del) begin
         for (int k = 0; k < DEPTH; k++) begin
            entries_ff[k] <= entries_in[k];
         end
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= code;
         rsp_count_ff  <= count_in;
         if ((action_ff == ACT_READ) && (code == STS_OK)) begin
            rsp_read_ff <= entries_ff[position_ff[IDX_W-1:0]];
         end else begin
            rsp_read_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign rsp_tdata = {rsp_read_ff, rsp_count_ff, rsp_status_ff};

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("count above depth");
   a_ins_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_ins |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("insert did not grow the list");
   a_del_shrinks: assert property (@(posedge clock) disable iff (reset)
      cmd.commit_del |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("delete did not shrink the list");
`endif

endmodule

[rtl/positional_insert_delete_list_core.sv]
// top level of the positional insert/delete list
//
// Holds a packed list of up to 32 signed 32-bit entries and a count. Each request
// item appends, inserts at a position (0..count), deletes at a position
// (0..count-1) or reads one entry, and gives exactly one result item with a
// status (ok, full, empty, position out of range), the count after the request
// and, for a successful read, the entry. A rejected request leaves the list as
// it was; the full and empty tests win over the position test. Each item runs in
// two steps: the request is captured, then, in the execute state, all cells
// compare their index with the position and shift in parallel while the result
// register is loaded. A new item is taken once the controller is back in idle and
// the result register is free or being drained, so it never overlaps two items.
// Entries above the count are never returned and need no reset.
module positional_insert_delete_list_core
   import pidl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // request item
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [TDATA_W-1:0] req_tdata,   // action[1:0], position[7:2], value[39:8]
   // result item
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata    // status[1:0], count[7:2], read_value[39:8]
);

   // command and status between controller and datapath
   cmd_type       cmd;
   dp_status_type dp_status;

   // sequencing and result handshake
   pidl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_status  (dp_status),
      .cmd        (cmd)
   );

   // storage cells, checks and result payload
   pidl_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .dp_status (dp_status),
      .rsp_tdata (rsp_tdata)
   );

endmodule
